// ===== src/hdb_pkg.sv =====
// Shared types, codes and the FCS-16 byte update for the HDLC byte deframer.
`default_nettype none

package hdb_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] FCS_START = 16'hFFFF;
    localparam logic [15:0] FCS_GOOD  = 16'hF0B8;
    localparam logic [15:0] FCS_POLY  = 16'h8408;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [1:0] FT_DATA = 2'd0;
    localparam logic [1:0] FT_ACK  = 2'd1;
    localparam logic [1:0] FT_NACK = 2'd2;

    localparam int LEN_W = 13;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data_byte;
        logic             frame_status;
        logic [1:0]       frame_type;
        logic [2:0]       seq_no;
        logic [LEN_W-1:0] payload_length;
    } hdb_result_t;

    // Reflected CRC-16 (RFC 1662), one byte per call.
    function automatic logic [15:0] fcs16_update(input logic [15:0] fcs,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = fcs ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0])
                c = (c >> 1) ^ FCS_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/hdb_rx_if.sv =====
// Valid/ready channel carrying one raw received byte per item.
`default_nettype none

interface hdb_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== src/hdb_res_if.sv =====
// Valid/ready channel carrying one deframer result item.
`default_nettype none

interface hdb_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic        frame_status;
    logic [1:0]  frame_type;
    logic [2:0]  seq_no;
    logic [12:0] payload_length;

    modport source (output valid, output kind, output data_byte, output frame_status,
                    output frame_type, output seq_no, output payload_length,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input frame_status,
                    input frame_type, input seq_no, input payload_length,
                    output ready);
endinterface

`default_nettype wire

// ===== src/hdb_engine.sv =====
// Deframer state and per-byte step: flag hunt, unescape, FCS, control decode, hold line.
`default_nettype none

module hdb_engine #(
    parameter int MAX_FRAME_BYTES = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire logic [7:0]           rx_byte,
    output      logic                 res_valid,
    output      hdb_pkg::hdb_result_t res
);
    import hdb_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 3);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES + 2);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

    logic             in_frame_reg,   in_frame_next;
    logic             escape_reg,     escape_next;
    logic [15:0]      crc_reg,        crc_next;
    logic [2:0]       raw_pos_reg,    raw_pos_next;
    logic [1:0]       hold_cnt_reg,   hold_cnt_next;
    logic [1:0]       ctrl_type_reg,  ctrl_type_next;
    logic [2:0]       ctrl_seq_reg,   ctrl_seq_next;
    logic [CNT_W-1:0] pay_cnt_reg,    pay_cnt_next;
    logic [7:0]       hold_reg [2];
    logic [7:0]       hold_next [2];

    logic [7:0]       ubyte;
    logic [CNT_W-1:0] len_full;

    assign ubyte    = escape_reg ? (rx_byte ^ ESC_XOR) : rx_byte;
    assign len_full = (pay_cnt_reg >= CNT_TWO) ? (pay_cnt_reg - CNT_TWO) : '0;

    always_comb
    begin
        in_frame_next  = in_frame_reg;
        escape_next    = escape_reg;
        crc_next       = crc_reg;
        raw_pos_next   = raw_pos_reg;
        hold_cnt_next  = hold_cnt_reg;
        ctrl_type_next = ctrl_type_reg;
        ctrl_seq_next  = ctrl_seq_reg;
        pay_cnt_next   = pay_cnt_reg;
        hold_next[0]   = hold_reg[0];
        hold_next[1]   = hold_reg[1];
        res_valid      = 1'b0;
        res            = '0;

        if (!in_frame_reg || rx_byte == FLAG_BYTE) begin
            if (in_frame_reg && raw_pos_reg == 3'd0) begin
                // repeated flag keeps the frame open
                escape_next = 1'b0;
            end
            else if (rx_byte == FLAG_BYTE) begin
                if (in_frame_reg) begin
                    res_valid          = 1'b1;
                    res.kind           = KIND_STATUS;
                    res.frame_status   = (raw_pos_reg < 3'd3) || (crc_reg != FCS_GOOD);
                    res.frame_type     = ctrl_type_reg;
                    res.seq_no         = ctrl_seq_reg;
                    res.payload_length = LEN_W'(len_full);
                end
                in_frame_next  = 1'b1;
                escape_next    = 1'b0;
                crc_next       = FCS_START;
                raw_pos_next   = 3'd0;
                hold_cnt_next  = 2'd0;
                ctrl_type_next = FT_DATA;
                ctrl_seq_next  = 3'd0;
                pay_cnt_next   = '0;
            end
        end
        else begin
            if (raw_pos_reg != 3'd7)
                raw_pos_next = raw_pos_reg + 3'd1;
            if (rx_byte == ESC_BYTE) begin
                escape_next = 1'b1;
            end
            else begin
                escape_next = 1'b0;
                crc_next    = fcs16_update(crc_reg, ubyte);
                if (raw_pos_reg == 3'd1) begin
                    if (ubyte[0]) begin
                        ctrl_type_next = (ubyte[3:2] == 2'b00) ? FT_ACK : FT_NACK;
                        ctrl_seq_next  = ubyte[7:5];
                    end
                    else begin
                        ctrl_type_next = FT_DATA;
                        ctrl_seq_next  = ubyte[3:1];
                    end
                end
                else if (raw_pos_reg != 3'd0) begin
                    if (pay_cnt_reg < CNT_MAX)
                        pay_cnt_next = pay_cnt_reg + CNT_W'(1);
                    if (hold_cnt_reg != 2'd2) begin
                        hold_next[hold_cnt_reg[0]] = ubyte;
                        hold_cnt_next              = hold_cnt_reg + 2'd1;
                    end
                    else begin
                        res_valid     = 1'b1;
                        res.kind      = KIND_PAYLOAD;
                        res.data_byte = hold_reg[0];
                        hold_next[0]  = hold_reg[1];
                        hold_next[1]  = ubyte;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_frame_reg  <= 1'b0;
            escape_reg    <= 1'b0;
            crc_reg       <= FCS_START;
            raw_pos_reg   <= 3'd0;
            hold_cnt_reg  <= 2'd0;
            ctrl_type_reg <= FT_DATA;
            ctrl_seq_reg  <= 3'd0;
            pay_cnt_reg   <= '0;
        end
        else if (fire) begin
            in_frame_reg  <= in_frame_next;
            escape_reg    <= escape_next;
            crc_reg       <= crc_next;
            raw_pos_reg   <= raw_pos_next;
            hold_cnt_reg  <= hold_cnt_next;
            ctrl_type_reg <= ctrl_type_next;
            ctrl_seq_reg  <= ctrl_seq_next;
            pay_cnt_reg   <= pay_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire) begin
            hold_reg[0] <= hold_next[0];
            hold_reg[1] <= hold_next[1];
        end
    end

    a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
        hold_cnt_reg != 2'd3)
        else $error("hold count out of range");

    a_payload_needs_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_valid && res.kind == KIND_PAYLOAD) |-> hold_cnt_reg == 2'd2)
        else $error("payload byte emitted before hold line filled");

    a_close_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_valid && res.kind == KIND_STATUS) |=>
            (in_frame_reg && crc_reg == FCS_START && raw_pos_reg == 3'd0
             && hold_cnt_reg == 2'd0))
        else $error("closing flag did not open a fresh frame");

    a_hunt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (raw_pos_reg == 3'd0 && hold_cnt_reg == 2'd0 && !escape_reg))
        else $error("frame state active while hunting");

endmodule

`default_nettype wire

// ===== src/hdb_out_reg.sv =====
// Result register: holds one result item until the sink takes it.
`default_nettype none

module hdb_out_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire hdb_pkg::hdb_result_t res,
    output      logic                 free,
    hdb_res_if.source                 out_ch
);
    import hdb_pkg::*;

    logic        valid_reg, valid_next;
    hdb_result_t res_reg;

    assign free = !valid_reg || out_ch.ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ch.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_ch.valid          = valid_reg;
    assign out_ch.kind           = res_reg.kind;
    assign out_ch.data_byte      = res_reg.data_byte;
    assign out_ch.frame_status   = res_reg.frame_status;
    assign out_ch.frame_type     = res_reg.frame_type;
    assign out_ch.seq_no         = res_reg.seq_no;
    assign out_ch.payload_length = res_reg.payload_length;

endmodule

`default_nettype wire

// ===== src/hdlc_byte_deframer_core.sv =====
// HDLC byte deframer top level: input register, deframer step, result register.
// A byte taken on rx is registered at the input; its result is registered at res.
// Throughput: one byte per cycle while res is ready; the FCS update is one byte wide.
// A byte gives zero or one result; bytes without a result still pass the deframer step.
// Reset (rst_n low, asynchronous) clears all control state; the block hunts for a flag.
`default_nettype none

module hdlc_byte_deframer_core #(
    parameter int MAX_FRAME_BYTES = 4096
) (
    input  wire logic clk,
    input  wire logic rst_n,
    hdb_rx_if.sink    rx,
    hdb_res_if.source res
);
    import hdb_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_free;
    logic        fire;
    logic        step_valid;
    hdb_result_t step_res;

    assign fire     = in_valid_reg && out_free;
    assign rx.ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx.ready)
            in_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
            in_byte_reg <= rx.rx_byte;
    end

    hdb_engine #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .rx_byte   (in_byte_reg),
        .res_valid (step_valid),
        .res       (step_res)
    );

    hdb_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (fire && step_valid),
        .res    (step_res),
        .free   (out_free),
        .out_ch (res)
    );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for hdlc_byte_deframer_core: framed byte streams against a predictor.
`default_nettype none

module tb;
    import hdb_pkg::*;

    localparam int MAX_BYTES    = 4096;
    localparam int LONG_PAYLOAD = 300;
    localparam int RANDOM_ITEMS = 1400;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 8;

    typedef logic [7:0] byte_q_t[$];

    logic clk = 1'b0;
    logic rst_n;

    hdb_rx_if  rx_ch ();
    hdb_res_if res_ch ();

    hdlc_byte_deframer_core #(
        .MAX_FRAME_BYTES(MAX_BYTES)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .rx   (rx_ch),
        .res  (res_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // deframer state as predicted
    logic        fr_open;
    logic        esc_armed;
    logic [15:0] fcs_acc;
    int unsigned raw_cnt;
    logic [7:0]  hold_buf[2];
    int unsigned hold_cnt;
    logic [1:0]  ctl_type;
    logic [2:0]  ctl_seq;
    int unsigned pay_cnt;

    hdb_result_t deframed_items[$];
    int          fails;
    int unsigned sent_count;
    int unsigned idle_cycles;
    bit          rx_quiet;
    bit          res_quiet;

    function automatic logic [15:0] fcs_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb)
                c = c ^ FCS_POLY;
        end
        return c;
    endfunction

    task automatic start_frame();
        fr_open   = 1'b1;
        esc_armed = 1'b0;
        fcs_acc   = FCS_START;
        raw_cnt   = 0;
        hold_cnt  = 0;
        ctl_type  = FT_DATA;
        ctl_seq   = '0;
        pay_cnt   = 0;
    endtask

    task automatic deframe_rx_byte(input logic [7:0] raw);
        logic [7:0]  b;
        int unsigned pos;
        hdb_result_t r;
        b = raw;
        if (!fr_open)
        begin
            if (b == FLAG_BYTE)
                start_frame();
            return;
        end
        if (b == FLAG_BYTE)
        begin
            if (raw_cnt == 0)
            begin
                esc_armed = 1'b0;
                return;
            end
            r                = '0;
            r.kind           = KIND_STATUS;
            r.frame_status   = (raw_cnt < 3) || (fcs_acc != FCS_GOOD);
            r.frame_type     = ctl_type;
            r.seq_no         = ctl_seq;
            r.payload_length = (pay_cnt >= 2) ? LEN_W'(pay_cnt - 2) : '0;
            deframed_items.push_back(r);
            start_frame();
            return;
        end
        pos = raw_cnt + 1;
        if (raw_cnt < 7)
            raw_cnt++;
        if (b == ESC_BYTE)
        begin
            esc_armed = 1'b1;
            return;
        end
        if (esc_armed)
        begin
            esc_armed = 1'b0;
            b = b ^ ESC_XOR;
        end
        fcs_acc = fcs_next(fcs_acc, b);
        if (pos == 2)
        begin
            if (b[0])
            begin
                ctl_type = (b[3:2] == 2'b00) ? FT_ACK : FT_NACK;
                ctl_seq  = b[7:5];
            end
            else
            begin
                ctl_type = FT_DATA;
                ctl_seq  = b[3:1];
            end
            return;
        end
        if (pos < 2)
            return;
        if (pay_cnt < MAX_BYTES + 2)
            pay_cnt++;
        if (hold_cnt < 2)
        begin
            hold_buf[hold_cnt] = b;
            hold_cnt++;
            return;
        end
        r           = '0;
        r.kind      = KIND_PAYLOAD;
        r.data_byte = hold_buf[0];
        hold_buf[0] = hold_buf[1];
        hold_buf[1] = b;
        deframed_items.push_back(r);
    endtask

    always @(posedge clk)
        if (rst_n === 1'b1 && rx_ch.valid && rx_ch.ready)
            deframe_rx_byte(rx_ch.rx_byte);

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin
        hdb_result_t want;
        if (rst_n === 1'b1 && res_ch.valid && res_ch.ready)
        begin
            if (deframed_items.size() == 0)
            begin
                $error("unexpected item: kind %0d data_byte 0x%02h", res_ch.kind,
                       res_ch.data_byte);
                fails++;
            end
            else
            begin
                want = deframed_items.pop_front();
                check_field("kind", 16'(want.kind), 16'(res_ch.kind));
                check_field("data_byte", 16'(want.data_byte), 16'(res_ch.data_byte));
                check_field("frame_status", 16'(want.frame_status), 16'(res_ch.frame_status));
                check_field("frame_type", 16'(want.frame_type), 16'(res_ch.frame_type));
                check_field("seq_no", 16'(want.seq_no), 16'(res_ch.seq_no));
                check_field("payload_length", 16'(want.payload_length),
                            16'(res_ch.payload_length));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len(input bit quiet);
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            int unsigned n;
            n = idle_len(res_quiet);
            if (n > 0)
            begin
                @(negedge clk);
                res_ch.ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(0, 8)) @(negedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = idle_len(rx_quiet);
        if (gap > 0)
        begin
            @(negedge clk);
            rx_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        sent_count++;
    endtask

    // byte stuffing; now and then escapes a plain byte, dbl puts a second escape in front
    task automatic send_stuffed(input logic [7:0] b, input bit dbl);
        logic [7:0] x;
        x = b ^ ESC_XOR;
        if (b == FLAG_BYTE || b == ESC_BYTE ||
            (x != FLAG_BYTE && x != ESC_BYTE && $urandom_range(0, 99) < 3))
        begin
            if (dbl)
                send_byte(ESC_BYTE);
            send_byte(ESC_BYTE);
            send_byte(x);
        end
        else
            send_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] addr, input logic [7:0] ctrl,
                              input byte_q_t pay, input bit fcs_ok, input bit with_open,
                              input bit dbl_esc);
        byte_q_t     body;
        logic [15:0] crc;
        body = pay;
        body.push_front(ctrl);
        body.push_front(addr);
        crc = FCS_START;
        foreach (body[k])
            crc = fcs_next(crc, body[k]);
        crc = ~crc;
        if (!fcs_ok)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
        if (with_open)
            send_byte(FLAG_BYTE);
        foreach (body[k])
            send_stuffed(body[k], dbl_esc);
        send_byte(FLAG_BYTE);
    endtask

    function automatic logic [7:0] ctrl_byte(input logic [1:0] ft, input logic [2:0] sq);
        logic [7:0] c;
        c = 8'($urandom);
        case (ft)
            FT_DATA:
            begin
                c[3:1] = sq;
                c[0]   = 1'b0;
            end
            FT_ACK:
            begin
                c[7:5] = sq;
                c[3:2] = 2'b00;
                c[0]   = 1'b1;
            end
            default:
            begin
                c[7:5] = sq;
                c[3:2] = 2'($urandom_range(1, 3));
                c[0]   = 1'b1;
            end
        endcase
        return c;
    endfunction

    function automatic logic [7:0] rand_ctrl();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'($urandom);
        if (r < 4)
            return ctrl_byte(FT_ACK, 3'($urandom));
        if (r < 6)
            return ctrl_byte(FT_NACK, 3'($urandom));
        return ctrl_byte(FT_DATA, 3'($urandom));
    endfunction

    function automatic logic [7:0] rand_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return FLAG_BYTE;
        if (r < 18)
            return ESC_BYTE;
        if (r < 22)
            return FLAG_BYTE ^ ESC_XOR;
        return 8'($urandom);
    endfunction

    task automatic test_directed();
        byte_q_t pay;
        // hunting ignores everything but a flag; the second flag is a repeat
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(ESC_BYTE);
        send_byte(FLAG_BYTE);
        send_byte(FLAG_BYTE);
        pay = {};
        send_frame(8'hFF, ctrl_byte(FT_DATA, 3'd7), pay, 1'b1, 1'b0, 1'b0);
        pay = {8'h00, 8'hFF, FLAG_BYTE, ESC_BYTE};
        send_frame(8'h00, ctrl_byte(FT_ACK, 3'd5), pay, 1'b1, 1'b0, 1'b1);
        pay = {8'hA5};
        send_frame(8'hFF, ctrl_byte(FT_NACK, 3'd2), pay, 1'b0, 1'b0, 1'b0);
        // too short, no control byte
        send_byte(8'hFF);
        send_byte(FLAG_BYTE);
        // one byte after control: length clamps to zero
        send_byte(8'hFF);
        send_byte(ctrl_byte(FT_DATA, 3'd1));
        send_byte(8'h55);
        send_byte(FLAG_BYTE);
        // flag cancels a pending escape
        send_byte(ESC_BYTE);
        send_byte(FLAG_BYTE);
    endtask

    // payload long enough that the length needs more than 8 bits
    task automatic test_long_frame();
        byte_q_t pay;
        for (int i = 0; i < LONG_PAYLOAD; i++)
            pay.push_back(8'($urandom));
        send_frame(8'hFF, ctrl_byte(FT_DATA, 3'($urandom)), pay, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_random();
        int unsigned start_cnt;
        int unsigned r;
        int unsigned n;
        byte_q_t     pay;
        start_cnt = sent_count;
        while (sent_count - start_cnt < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                rx_quiet  = ($urandom_range(0, 3) == 0);
                res_quiet = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                pay = {};
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
                for (int k = 0; k < n; k++)
                    pay.push_back(rand_byte());
                send_frame(rand_byte(), rand_ctrl(), pay, $urandom_range(0, 9) != 0,
                           $urandom_range(0, 1), $urandom_range(0, 9) == 0);
            end
            else if (r < 90)
            begin
                // truncated frame, sometimes ending on an escape
                n = $urandom_range(0, 5);
                for (int k = 0; k < n; k++)
                    send_byte(rand_byte());
                if ($urandom_range(0, 1))
                    send_byte(ESC_BYTE);
                send_byte(FLAG_BYTE);
            end
            else
            begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++)
                    send_byte(8'($urandom));
            end
        end
        send_byte(FLAG_BYTE);
        rx_quiet  = 1'b0;
        res_quiet = 1'b0;
    endtask

    initial
    begin
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready  = 1'b0;
        rst_n         = 1'b0;
        fails         = 0;
        sent_count    = 0;
        idle_cycles   = 0;
        rx_quiet      = 1'b0;
        res_quiet     = 1'b0;
        fr_open       = 1'b0;
        esc_armed     = 1'b0;
        fcs_acc       = FCS_START;
        raw_cnt       = 0;
        hold_cnt      = 0;
        ctl_type      = FT_DATA;
        ctl_seq       = '0;
        pay_cnt       = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_long_frame();
        test_random();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (deframed_items.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/hdb_pkg.sv
src/hdb_rx_if.sv
src/hdb_res_if.sv
src/hdb_engine.sv
src/hdb_out_reg.sv
src/hdlc_byte_deframer_core.sv
sim/tb.sv
